@@ rtl/core/sqfe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sqfe_pkg
// Shared types and constants of the square factor extractor.
// ---------------------------------------------------------------------------
package sqfe_pkg;

  localparam int PRIME_TABLE_MAX = 6542;

  typedef struct packed {
    logic load;      // Take a new value and restart the walk.
    logic div_start; // Start one division of the remainder by p*p.
    logic commit;    // Accept the last quotient: rem = q, root *= p.
    logic next_prime;
  } sqfe_cmd_t;

  typedef struct packed {
    logic below;     // Remainder is below p*p.
    logic div_busy;
    logic zero_rem;  // Last division left no remainder.
    logic last_prime;
  } sqfe_status_t;

endpackage
`default_nettype wire

@@ rtl/core/sqfe_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sqfe_ctrl
// Sequencer that walks the prime table and drives the datapath.
// ---------------------------------------------------------------------------
module sqfe_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire sqfe_pkg::sqfe_status_t status,
  output sqfe_pkg::sqfe_cmd_t        cmd
);
  import sqfe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_DIV, S_WAIT, S_DONE
  } state_t;

  state_t state;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: cmd.load = in_valid;
      S_CHECK: cmd.div_start = !status.below;
      S_WAIT: begin
        if (!status.div_busy) begin
          cmd.commit = status.zero_rem;
          cmd.next_prime = !status.zero_rem && !status.last_prime;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_CHECK;
        S_CHECK: state <= status.below ? S_DONE : S_DIV;
        S_DIV: state <= S_WAIT;
        S_WAIT: begin
          if (!status.div_busy) begin
            if (status.zero_rem) state <= S_CHECK;
            else if (status.last_prime) state <= S_DONE;
            else state <= S_CHECK;
          end
        end
        S_DONE: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/sqfe_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sqfe_datapath
// Prime table ROM, restoring divider and result registers.
// ---------------------------------------------------------------------------
module sqfe_datapath #(
  parameter int PRIME_COUNT = 1229,
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [63:0]            value,
  input  wire sqfe_pkg::sqfe_cmd_t    cmd,
  output sqfe_pkg::sqfe_status_t      status,
  output logic [31:0]                 square_root_part,
  output logic [63:0]                 square_free_part
);
  import sqfe_pkg::*;

  localparam int PC = (PRIME_COUNT < 1) ? 1 :
                      (PRIME_COUNT > PRIME_TABLE_MAX) ? PRIME_TABLE_MAX : PRIME_COUNT;
  localparam int IW = (PC > 1) ? $clog2(PC) : 1;
  localparam int CW = $clog2(VALUE_WIDTH + 1);
  localparam int DW = VALUE_WIDTH + 1;

  logic [VALUE_WIDTH-1:0] rem, quo, quo_next, work;
  logic [VALUE_WIDTH:0]   part, part_sh;
  logic                   part_ge;
  logic [31:0]            pp;
  logic [15:0]            p;
  logic [31:0]            root;
  logic [IW-1:0]          idx;
  logic [IW-1:0]          rd_addr;
  logic [CW-1:0]          cnt;
  logic                   busy;
  logic [15:0]            prime_rom [PC];

  // The table is built once at start-up by a sieve over all 16-bit values.
  initial begin : build_prime_rom
    bit composite [65536];
    int found;
    found = 0;
    for (int c = 2; c < 65536; c++) begin
      if (!composite[c] && found < PC) begin
        prime_rom[found] = 16'(c);
        found++;
        if (c < 256) begin
          for (int m = c * c; m < 65536; m += c) composite[m] = 1'b1;
        end
      end
    end
  end

  // The ROM output register follows the index, so p is current as soon as
  // the index has moved.
  always_comb begin
    rd_addr = idx;
    if (cmd.load) rd_addr = '0;
    else if (cmd.next_prime) rd_addr = idx + IW'(1);
  end

  always_ff @(posedge clk) begin
    p <= prime_rom[rd_addr];
  end

  assign pp = {16'd0, p} * {16'd0, p};
  assign part_sh = {part[VALUE_WIDTH-1:0], work[VALUE_WIDTH-1]};
  assign part_ge = (65'(part_sh) >= 65'(pp));
  assign quo_next = {quo[VALUE_WIDTH-2:0], part_ge};

  assign status.below      = (64'(rem) < 64'(pp));
  assign status.div_busy   = busy;
  assign status.zero_rem   = (part == '0);
  assign status.last_prime = (idx == IW'(PC - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else begin
      if (cmd.load) begin
        rem  <= value[VALUE_WIDTH-1:0];
        root <= 32'd1;
        idx  <= '0;
      end
      if (cmd.div_start) begin
        busy <= 1'b1;
        work <= rem;
        part <= '0;
        quo  <= '0;
        cnt  <= CW'(VALUE_WIDTH);
      end else if (busy) begin
        if (part_ge)
          part <= part_sh - DW'(pp);
        else
          part <= part_sh;
        quo  <= quo_next;
        work <= {work[VALUE_WIDTH-2:0], 1'b0};
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) busy <= 1'b0;
      end
      if (cmd.commit) begin
        rem  <= quo;
        root <= root * {16'd0, p};
      end
      if (cmd.next_prime) begin
        idx <= idx + IW'(1);
      end
    end
  end

  assign square_root_part = root;
  assign square_free_part = 64'(rem);
endmodule
`default_nettype wire

@@ rtl/core/square_factor_extractor_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sequence: each division attempt runs a compare, the serial divide steps and a
// decide; one attempt per table prime tried plus one per square divided out,
// and the walk ends once the remainder is below p*p or the last prime is tried.
// Throughput: one request at a time; the next is taken after the result.
// Reset: synchronous; clears the sequencer, no request is held afterwards.
// ---------------------------------------------------------------------------
// square_factor_extractor_unit
// Splits a value into a square part and a remainder with no table prime squared.
// ---------------------------------------------------------------------------
module square_factor_extractor_unit #(
  parameter int PRIME_COUNT = 1229,
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      square_root_part,
  output logic [63:0]      square_free_part
);
  import sqfe_pkg::*;

  sqfe_cmd_t    cmd;
  sqfe_status_t status;

  sqfe_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .status, .cmd
  );

  sqfe_datapath #(.PRIME_COUNT(PRIME_COUNT), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk, .rst, .value, .cmd, .status, .square_root_part, .square_free_part
  );
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks square_factor_extractor_unit: every value sent is split by a local
// trial-division predictor and each result is compared in arrival order.
// ---------------------------------------------------------------------------

class square_split_scoreboard;
  typedef struct {
    bit [63:0] value;
    bit [31:0] root;
    bit [63:0] free;
  } split_t;

  split_t pending_splits[$];
  bit [15:0] primes[];
  int errors;

  function new(int prime_count);
    int found;
    bit no_factor;
    primes = new[prime_count];
    found = 0;
    errors = 0;
    for (int cand = 2; cand < 65536 && found < prime_count; cand++) begin
      no_factor = 1;
      for (int k = 0; k < found; k++) begin
        if (primes[k] * primes[k] > cand) break;
        if (cand % primes[k] == 0) begin
          no_factor = 0;
          break;
        end
      end
      if (no_factor) begin
        primes[found] = 16'(cand);
        found++;
      end
    end
  endfunction

  function void note_request(bit [63:0] n);
    split_t s;
    bit [63:0] rem;
    bit [63:0] root;
    bit [63:0] p;
    bit [63:0] pp;
    rem = n;
    root = 1;
    for (int i = 0; i < primes.size(); i++) begin
      p = primes[i];
      pp = p * p;
      if (rem < pp) break;
      while (rem % pp == 0) begin
        rem = rem / pp;
        root = root * p;
      end
    end
    s.value = n;
    s.root = root[31:0];
    s.free = rem;
    pending_splits.push_back(s);
  endfunction

  function void check_result(bit [31:0] root, bit [63:0] free);
    split_t s;
    if (pending_splits.size() == 0) begin
      $display("%0t: unexpected result root=%0d free=%0d", $time, root, free);
      errors++;
      return;
    end
    s = pending_splits.pop_front();
    if (root !== s.root) begin
      $display("%0t: value %0d square_root_part expected %0d actual %0d",
               $time, s.value, s.root, root);
      errors++;
    end
    if (free !== s.free) begin
      $display("%0t: value %0d square_free_part expected %0d actual %0d",
               $time, s.value, s.free, free);
      errors++;
    end
  endfunction

  function int outstanding();
    return pending_splits.size();
  endfunction
endclass

module testbench;
  import sqfe_pkg::*;

  localparam int PRIME_COUNT = 1229;
  localparam int IDLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [63:0] value;
  logic out_valid;
  logic out_stall;
  logic [31:0] square_root_part;
  logic [63:0] square_free_part;

  square_split_scoreboard splits;
  bit hold_request;
  int idle_cycles;
  int burst_left;

  square_factor_extractor_unit #(
    .PRIME_COUNT(PRIME_COUNT),
    .VALUE_WIDTH(64)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .square_root_part(square_root_part),
    .square_free_part(square_free_part)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    splits = new(PRIME_COUNT);
    rst = 1'b1;
    in_valid = 1'b0;
    value = '0;
    out_stall = 1'b0;
    hold_request = 0;
    idle_cycles = 0;
    burst_left = 0;
  end

  // Receiver: checks accepted results and stalls on its own pattern. The long
  // hold outlasts the slowest request, so a finished result is kept waiting.
  initial begin
    int hold_left;
    int mode;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        splits.check_result(square_root_part, square_free_part);
      if (hold_request) begin
        hold_request = 0;
        hold_left = 100000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        mode = ($time / 20000) % 3;
        if (mode == 0) out_stall <= 1'b0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[square_factor_extractor_unit] ERROR");
      $finish;
    end
  end

  task automatic send_value(input bit [63:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (in_stall);
    splits.note_request(v);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (splits.outstanding() > 0) @(posedge clk);
  endtask

  // A product of small prime squares times a small cofactor, so the walk
  // finishes early and the division loop is exercised many times.
  function automatic bit [63:0] squareful_value();
    bit [63:0] v;
    bit [63:0] p;
    v = $urandom_range(1, 2000);
    repeat ($urandom_range(0, 6)) begin
      p = splits.primes[$urandom_range(0, 40)];
      if (v < (64'd1 << 40)) v = v * p * p;
    end
    return v;
  endfunction

  initial begin
    bit [63:0] v;
    int kind;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd2);
    send_value(64'd4);
    send_value(64'd8);
    send_value(64'd36);
    send_value(64'd720);
    send_value(64'd9973 * 64'd9973);
    send_value(64'd9973 * 64'd9973 * 64'd9973 * 64'd9973 * 64'd5);
    // The square of a prime beyond the table stays in the remainder.
    send_value(64'd10007 * 64'd10007 * 64'd3);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'h4000_0000_0000_0000);
    send_value(64'hFFFF_FFFF_FFFF_FFFF);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(64'h5555_5555_5555_5555);
    send_value(64'd9409 * 64'd1000003);
    drain_results();

    for (int i = 0; i < 100; i++) begin
      if (i == 40) hold_request = 1;
      if (i == 70) drain_results();
      kind = $urandom_range(0, 19);
      if (kind < 13) v = squareful_value();
      else if (kind < 16) v = $urandom_range(0, 100000);
      else v = {$urandom, $urandom} >> $urandom_range(0, 63);
      send_value(v);
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (splits.errors == 0 && splits.outstanding() == 0) begin
      $display("[square_factor_extractor_unit] OK");
    end else begin
      $display("[square_factor_extractor_unit] ERROR");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/sqfe_pkg.sv
rtl/core/sqfe_ctrl.sv
rtl/core/sqfe_datapath.sv
rtl/core/square_factor_extractor_unit.sv
tb/testbench.sv
